FILE: hdl/rspd_pkg.sv
// Shared types and constants of the ramp speed tracker.
package rspd_pkg;

  localparam int LEVEL_W    = 32;
  localparam int REM_W      = 17;
  localparam int DIVR_W     = 16;
  localparam int RATE_W     = 31;
  localparam int ACC_W      = 33;
  localparam int MAG_W      = 32;
  localparam int SUM_W      = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [DIVR_W-1:0] CONTROL_RATE_RST = 16'd20000;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_STEP    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTROL_RATE = 2'd0,
    REG_RISE_RATE    = 2'd1,
    REG_FALL_RATE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ACC   = 5'b00010,
    ST_PREP  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_SUM   = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/rspd_in_if.sv
// Command channel: restart or step command with its value.
interface rspd_in_if;
  import rspd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [LEVEL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

FILE: hdl/rspd_out_if.sv
// Result channel: ramped level after each step.
interface rspd_out_if;
  import rspd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

FILE: hdl/rspd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rspd_div (
  input  logic                            clk,
  input  logic                            rst,
  input  rspd_pkg::div_ctrl_t             ctrl,
  input  logic [rspd_pkg::MAG_W-1:0]      dividend,
  input  logic [rspd_pkg::DIVR_W-1:0]     divisor,
  output rspd_pkg::div_stat_t             stat,
  output logic [rspd_pkg::MAG_W-1:0]      quotient,
  output logic [rspd_pkg::DIVR_W-1:0]     remainder
);
  import rspd_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [MAG_W-1:0]  quo;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvsr;
  logic [DIVR_W+1:0] diff;
  logic              neg;

  // Trial subtract of the divisor from the shifted partial remainder
  assign diff = {1'b0, rem, quo[MAG_W-1]} - {2'b00, dvsr};
  assign neg  = diff[DIVR_W+1];

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift quotient bits in, keep or restore the partial remainder
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      count <= CNT_W'(MAG_W - 1);
      quo   <= dividend;
      rem   <= '0;
      dvsr  <= divisor;
    end else if (busy) begin
      count <= count - 1'b1;
      quo   <= {quo[MAG_W-2:0], ~neg};
      rem   <= neg ? {rem[DIVR_W-2:0], quo[MAG_W-1]} : diff[DIVR_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(stat.busy))
    else $error("divider done without a run");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (stat.done && dvsr != '0) |-> (rem < dvsr))
    else $error("divider remainder not below divisor");
  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && count != '0) |-> !ctrl.start)
    else $error("divider restarted mid run");

endmodule

FILE: hdl/ramp_speed_tracker.sv
// Acceleration-limited ramp toward a goal level, top level.
// Restart command: loads the level, gives no result.
// Step command: accumulate, prepare, divide (32-iteration serial divider) and sum states,
// sum alone when the goal equals the level; a step holds off the next command until done.
// The result register lets the next command be accepted while a result waits.
// Synchronous active-high reset: level and remainder 0, control_rate 20000, rates 0.
module ramp_speed_tracker (
  input  logic                                clk,
  input  logic                                rst,
  rspd_in_if.sink                             cmd_ch,
  rspd_out_if.source                          lvl_ch,
  input  logic                                cfg_we,
  input  logic [rspd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rspd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rspd_pkg::*;

  state_t state;

  logic [DIVR_W-1:0] control_rate;
  logic [RATE_W-1:0] rise_rate;
  logic [RATE_W-1:0] fall_rate;

  logic signed [LEVEL_W-1:0] level;
  logic signed [REM_W-1:0]   remainder;
  logic signed [LEVEL_W-1:0] goal;
  logic                      dir_up;
  logic                      away;
  logic                      hold;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_neg;
  logic [MAG_W-1:0]          acc_mag;
  logic signed [LEVEL_W-1:0] new_level;
  logic signed [REM_W-1:0]   new_rem;
  logic                      out_valid;
  logic signed [LEVEL_W-1:0] out_level;
  logic                      div_launch;

  logic                      cmd_take;
  logic                      out_free;
  logic [DIVR_W-1:0]         divisor;
  logic [RATE_W-1:0]         rate_sel;
  logic signed [ACC_W-1:0]   rate_ext;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   acc_abs;
  logic signed [ACC_W-1:0]   quo_s;
  logic signed [SUM_W-1:0]   lvl_sum;
  logic signed [LEVEL_W-1:0] lvl_sat;
  logic signed [REM_W-1:0]   rem_s;
  logic                      reach_goal;
  logic                      reach_zero;
  logic signed [LEVEL_W-1:0] fin_level;
  logic signed [REM_W-1:0]   fin_rem;

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [MAG_W-1:0]      div_quo;
  logic [DIVR_W-1:0]     div_rem;

  assign cmd_take     = cmd_ch.valid && cmd_ch.ready;
  assign cmd_ch.ready = (state == ST_IDLE);
  assign out_free     = !out_valid || lvl_ch.ready;
  assign divisor      = (control_rate == '0) ? DIVR_W'(1) : control_rate;

  // Pick the rate and add it to the remainder
  assign rate_sel = away ? rise_rate : fall_rate;
  assign rate_ext = dir_up ? $signed({2'b00, rate_sel}) : -$signed({2'b00, rate_sel});
  assign acc_sum  = $signed({{(ACC_W-REM_W){remainder[REM_W-1]}}, remainder}) + rate_ext;
  assign acc_abs  = acc[ACC_W-1] ? -acc : acc;

  // Signed quotient and remainder, saturating level update
  assign quo_s   = acc_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign lvl_sum = $signed({{(SUM_W-LEVEL_W){level[LEVEL_W-1]}}, level})
                 + $signed({quo_s[ACC_W-1], quo_s});
  assign rem_s   = acc_neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});

  always_comb begin
    if (lvl_sum > $signed(SUM_W'({1'b0, {(LEVEL_W-1){1'b1}}}))) begin
      lvl_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
    end else if (lvl_sum < -$signed(SUM_W'({1'b1, {(LEVEL_W-1){1'b0}}}))) begin
      lvl_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
    end else begin
      lvl_sat = lvl_sum[LEVEL_W-1:0];
    end
  end

  // Keep the level on a hold, clamp at the goal, stop at zero on a crossing
  always_comb begin
    reach_goal = 1'b0;
    reach_zero = 1'b0;
    fin_level  = new_level;
    fin_rem    = new_rem;
    if (dir_up) begin
      if (away || goal <= 0) begin
        reach_goal = (new_level >= goal);
      end else begin
        reach_zero = (new_level >= 0);
      end
    end else begin
      if (away || goal >= 0) begin
        reach_goal = (new_level <= goal);
      end else begin
        reach_zero = (new_level <= 0);
      end
    end
    if (hold) begin
      fin_level = level;
      fin_rem   = remainder;
    end else if (reach_goal) begin
      fin_level = goal;
      fin_rem   = '0;
    end else if (reach_zero) begin
      fin_level = '0;
      fin_rem   = '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      control_rate <= CONTROL_RATE_RST;
      rise_rate    <= '0;
      fall_rate    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CONTROL_RATE: control_rate <= cfg_data[DIVR_W-1:0];
        REG_RISE_RATE:    rise_rate    <= cfg_data[RATE_W-1:0];
        REG_FALL_RATE:    fall_rate    <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      level      <= '0;
      remainder  <= '0;
      out_valid  <= 1'b0;
      div_launch <= 1'b0;
    end else begin
      // Raise the result on a finished step, drop it once taken
      if (state == ST_SUM && out_free) begin
        out_valid <= 1'b1;
      end else if (lvl_ch.valid && lvl_ch.ready) begin
        out_valid <= 1'b0;
      end
      div_launch <= (state == ST_PREP);
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            if (cmd_ch.command == CMD_RESTART) begin
              level     <= cmd_ch.value;
              remainder <= '0;
            end else if (cmd_ch.value == level) begin
              state <= ST_SUM;
            end else begin
              state <= ST_ACC;
            end
          end
        end
        ST_ACC:  state <= ST_PREP;
        ST_PREP: state <= ST_DIV;
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            level     <= fin_level;
            remainder <= fin_rem;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_take) begin
      goal   <= cmd_ch.value;
      hold   <= (cmd_ch.value == level);
      dir_up <= (cmd_ch.value > level);
      away   <= (cmd_ch.value > level) ? (level >= 0) : (level <= 0);
    end
    if (state == ST_ACC) begin
      acc <= acc_sum;
    end
    if (state == ST_PREP) begin
      acc_neg <= acc[ACC_W-1];
      acc_mag <= acc_abs[MAG_W-1:0];
    end
    if (state == ST_DIV && div_stat.done) begin
      new_level <= lvl_sat;
      new_rem   <= rem_s;
    end
    if (state == ST_SUM && out_free) begin
      out_level <= fin_level;
    end
  end

  // Launch the divider once the magnitude is registered
  always_comb begin
    div_ctrl.start = (state == ST_DIV) && !div_stat.busy && !div_stat.done && div_launch;
  end

  rspd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (acc_mag),
    .divisor   (divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign lvl_ch.valid = out_valid;
  assign lvl_ch.level = out_level;

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");
  a_restart_load: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd_ch.command == CMD_RESTART) |=>
      (level == $past(cmd_ch.value) && remainder == '0))
    else $error("restart did not load the level");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (lvl_ch.valid && lvl_ch.ready && state != ST_SUM) |=> !lvl_ch.valid)
    else $error("result repeated");
  a_busy_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !cmd_ch.ready)
    else $error("command taken while dividing");

endmodule
